/* hw/rtl/dfq_pkg.sv */
`timescale 1ns / 1ps

package dfq_pkg;

   // Payload field widths, fixed by the channel format.
   localparam int ACTION_W   = 1;
   localparam int ITEM_ID_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int ITEM_OUT_W = 16;
   localparam int COUNT_W    = 5;

   // Default sizing of the queue.
   localparam int DFQ_DEPTH   = 16;
   localparam int DFQ_ID_BITS = 16;

   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [ITEM_ID_W-1:0]  item_id_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [ITEM_OUT_W-1:0] item_out_type;
   typedef logic [COUNT_W-1:0]    count_type;

   localparam action_type ACTION_INSERT = 1'b0;
   localparam action_type ACTION_REMOVE = 1'b1;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_REJECT = 2'd1;
   localparam status_type STATUS_EMPTY  = 2'd2;

endpackage

/* hw/rtl/dfq_if.sv */
`timescale 1ns / 1ps

// Request channel: one queue operation per word.
interface dfq_req_if;
   logic                 valid;
   logic                 ready;
   dfq_pkg::action_type  action;
   dfq_pkg::item_id_type item_id;

   modport source (output valid, output action, output item_id, input ready);
   modport sink   (input valid, input action, input item_id, output ready);
endinterface

// Response channel: one result word per request.
interface dfq_rsp_if;
   logic                  valid;
   logic                  ready;
   dfq_pkg::status_type   status;
   dfq_pkg::item_out_type item_out;
   dfq_pkg::count_type    entry_count;

   modport source (output valid, output status, output item_out, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input item_out, input entry_count,
                   output ready);
endinterface

/* hw/rtl/dfq_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module dfq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dedup_fifo_queue_unit.sv */
`timescale 1ns / 1ps

// FIFO queue of nonzero identifiers that refuses duplicates. A request word
// either inserts item_id at the tail (rejected with status 1 when the id is
// zero, already queued, or the queue is full) or removes the head entry
// (status 2 when empty). Every request yields one response word carrying the
// status, the removed id (zero if none) and the entry count after the request.
// Entries live in a ring memory of DEPTH words with one read port, so the
// duplicate check walks the queued entries one per cycle. An insert that is
// checked walks all of them (stopping early when a duplicate turns up) and
// then appends; a remove reads the head entry, and an insert refused for null
// id or full queue goes straight to its result. A finished result also waits
// while the output register still holds an untaken response word. One
// request is in flight at a time; a finished response waits in the output
// register while the next request is accepted.
// The queue is empty after reset; no memory clearing pass is needed.
module dedup_fifo_queue_unit #(
   parameter int DEPTH   = dfq_pkg::DFQ_DEPTH,
   parameter int ID_BITS = dfq_pkg::DFQ_ID_BITS
) (
   input logic clock,
   input logic reset,
   dfq_req_if.sink   req_bus,
   dfq_rsp_if.source rsp_bus
);

   import dfq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   status_type         res_status_ff, res_status_in;
   item_out_type       res_item_ff, res_item_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   item_out_type       rsp_item_ff, rsp_item_in;
   count_type          rsp_count_ff, rsp_count_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [ID_BITS-1:0] ram_rd_data;
   logic [ID_BITS-1:0] req_id;
   logic               out_free;
   logic               hit;

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
      next_pos = (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   // Take the identifier in its low ID_BITS bits, zero-extended if wider.
   assign req_id   = ID_BITS'({{ID_BITS{1'b0}}, req_bus.item_id});
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign hit      = pend_ff && (ram_rd_data == id_ff);

   // Scan reads walk from head; otherwise keep the head entry addressed so a
   // remove finds it in the cycle after acceptance.
   assign ram_rd_addr = (state_ff == ST_SCAN) ? ptr_ff : head_ff;

   dfq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (id_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      id_in         = id_ff;
      res_status_in = res_status_ff;
      res_item_in   = res_item_ff;
      ram_wr_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               id_in       = req_id;
               res_item_in = '0;
               if (req_bus.action == ACTION_REMOVE) begin
                  if (occ_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_FINISH;
                  end else begin
                     state_in = ST_RDWAIT;
                  end
               end else if (req_id == '0 || occ_ff == FULL_CNT) begin
                  res_status_in = STATUS_REJECT;
                  state_in      = ST_FINISH;
               end else begin
                  ptr_in   = head_ff;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // Duplicate: drop the insert.
               res_status_in = STATUS_REJECT;
               state_in      = ST_FINISH;
            end else if (cnt_ff != occ_ff) begin
               // Issue next read; compare it in the next cycle.
               ptr_in  = next_pos(ptr_ff);
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               // All entries checked: append at tail.
               ram_wr_en     = 1'b1;
               tail_in       = next_pos(tail_ff);
               occ_in        = occ_ff + 1'b1;
               res_status_in = STATUS_OK;
               state_in      = ST_FINISH;
            end
         end
         ST_RDWAIT: begin
            res_item_in   = ITEM_OUT_W'({{ITEM_OUT_W{1'b0}}, ram_rd_data});
            head_in       = next_pos(head_ff);
            occ_in        = occ_ff - 1'b1;
            res_status_in = STATUS_OK;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: hold until taken, load when the result is done.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_count_in  = rsp_count_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_item_in   = res_item_ff;
         rsp_count_in  = COUNT_W'({{COUNT_W{1'b0}}, occ_ff});
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      id_ff         <= id_in;
      res_status_ff <= res_status_in;
      res_item_ff   <= res_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.item_out    = rsp_item_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the duplicate-rejecting FIFO queue.
// Keep a shadow ring of the queue, predict each response word when its
// request word is accepted, and compare every response word in arrival order.
module tb_top;
   import dfq_pkg::*;

   localparam int DEPTH       = DFQ_DEPTH;
   localparam int MAX_REPORTS = 10;
   localparam int TAIL_CYCLES = 40;   // longest insert walk plus slack

   typedef struct packed {
      action_type  action;
      item_id_type item_id;
   } queue_op_type;

   typedef struct packed {
      status_type   status;
      item_out_type item_out;
      count_type    entry_count;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dfq_req_if req_ch ();
   dfq_rsp_if rsp_ch ();

   dedup_fifo_queue_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the queue: ring of ids, head, tail and fill level.
   item_id_type id_ring [DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   int unsigned ring_fill = 0;

   queue_op_type  request_backlog  [$];   // words waiting to be sent
   queue_rsp_type expected_results [$];   // predicted response words, oldest first

   int unsigned send_idle_pct  = 0;
   int unsigned take_stall_pct = 0;
   int unsigned mismatch_count = 0;

   // Apply one queue operation to the shadow ring and return its response.
   function automatic queue_rsp_type apply_queue_op(input queue_op_type op);
      queue_rsp_type rsp;
      int unsigned   pos;
      logic          held;
      rsp.status   = STATUS_OK;
      rsp.item_out = '0;
      held         = 1'b0;
      pos          = ring_head;
      if (op.action == ACTION_INSERT) begin
         // Scan only occupied slots; stale ring contents never count as held.
         for (int n = 0; n < ring_fill; n++) begin
            if (id_ring[pos] == op.item_id) held = 1'b1;
            pos = (pos + 1) % DEPTH;
         end
         if (op.item_id == '0 || ring_fill == DEPTH || held) begin
            rsp.status = STATUS_REJECT;
         end else begin
            id_ring[ring_tail] = op.item_id;
            ring_tail          = (ring_tail + 1) % DEPTH;
            ring_fill++;
         end
      end else begin
         if (ring_fill == 0) begin
            rsp.status = STATUS_EMPTY;
         end else begin
            rsp.item_out = id_ring[ring_head];
            ring_head    = (ring_head + 1) % DEPTH;
            ring_fill--;
         end
      end
      rsp.entry_count = count_type'(ring_fill);
      return rsp;
   endfunction

   function automatic void log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
   endfunction

   // Request driver: on acceptance predict the response, then advance to the
   // next backlog word or drop valid while idling or out of words.
   always @(posedge clock) begin
      queue_op_type sent_op;
      queue_op_type next_op;
      logic         word_done;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         word_done = req_ch.valid && req_ch.ready;
         if (word_done) begin
            sent_op.action  = req_ch.action;
            sent_op.item_id = req_ch.item_id;
            expected_results.push_back(apply_queue_op(sent_op));
         end
         // Hold the current word until the queue takes it.
         if (!req_ch.valid || word_done) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_op = request_backlog.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.action  <= next_op.action;
               req_ch.item_id <= next_op.item_id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted word against the oldest prediction,
   // then pick ready for the next cycle.
   always @(posedge clock) begin
      queue_rsp_type got;
      queue_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status      = rsp_ch.status;
            got.item_out    = rsp_ch.item_out;
            got.entry_count = rsp_ch.entry_count;
            if (expected_results.size() == 0) begin
               log_mismatch($sformatf("response with nothing pending: status=%0d item=%h count=%0d",
                                      got.status, got.item_out, got.entry_count));
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.item_out !== want.item_out ||
                   got.entry_count !== want.entry_count) begin
                  log_mismatch($sformatf(
                     "expected status=%0d item=%h count=%0d, got status=%0d item=%h count=%0d",
                     want.status, want.item_out, want.entry_count,
                     got.status, got.item_out, got.entry_count));
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= take_stall_pct);
      end
   end

   task automatic add_op(input action_type action, input item_id_type item_id);
      queue_op_type op;
      op.action  = action;
      op.item_id = item_id;
      request_backlog.push_back(op);
   endtask

   // Mostly ids from a small pool so duplicates and a full queue happen often;
   // some wide random ids and some null ids on top.
   function automatic item_id_type pick_id();
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2, 3: return item_id_type'($urandom_range(0, 65535));
         default: return item_id_type'($urandom_range(1, 24));
      endcase
   endfunction

   // Random traffic in bursts with a shifting insert bias so the queue keeps
   // filling up, draining and wrapping around the ring.
   task automatic add_random(input int unsigned total);
      int unsigned left;
      int unsigned burst;
      int unsigned ins_pct;
      left = total;
      while (left > 0) begin
         burst = $urandom_range(4, 24);
         if (burst > left) burst = left;
         case ($urandom_range(0, 3))
            0:       ins_pct = 25;
            1:       ins_pct = 50;
            2:       ins_pct = 75;
            default: ins_pct = 95;
         endcase
         repeat (burst) begin
            if ($urandom_range(0, 99) < ins_pct) add_op(ACTION_INSERT, pick_id());
            else add_op(ACTION_REMOVE, item_id_type'($urandom_range(0, 65535)));
         end
         left -= burst;
      end
   endtask

   // Wait until every word is sent and every response has come back.
   task automatic drain();
      while (request_backlog.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.action  = ACTION_INSERT;
      req_ch.item_id = '0;
      rsp_ch.ready   = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles sometimes, receiver stalls a lot.
      send_idle_pct  = 29;
      take_stall_pct = 84;

      // Directed: empty remove, null insert, largest id and its duplicate.
      add_op(ACTION_REMOVE, 16'h1234);
      add_op(ACTION_INSERT, 16'h0000);
      add_op(ACTION_INSERT, 16'hFFFF);
      add_op(ACTION_INSERT, 16'hFFFF);
      add_op(ACTION_REMOVE, 16'hFFFF);
      // Fill to capacity, then hit the full queue with a new id and a held one.
      for (int i = 1; i <= DEPTH; i++) add_op(ACTION_INSERT, item_id_type'(i * 16'h0F0F));
      add_op(ACTION_INSERT, 16'h8001);
      add_op(ACTION_INSERT, 16'h0F0F);
      add_op(ACTION_REMOVE, 16'h0000);

      add_random(400);
      drain();

      // Phase two: sender idles a lot, receiver stalls sometimes.
      send_idle_pct  = 84;
      take_stall_pct = 29;
      add_random(400);
      drain();

      // Phase three: back to back on both sides.
      send_idle_pct  = 0;
      take_stall_pct = 0;
      add_random(400);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_if.sv
hw/rtl/dfq_ram.sv
hw/rtl/dedup_fifo_queue_unit.sv
tb/sv/tb_top.sv
